### rtl/nearest_neighbor_image_scaler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor image scaler
// Wrappers for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nns_pkg.sv
// ----------------------------------------------------------------------------
// Scaler package
// Widths, codes and the controller/datapath signal groups of the scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nns_pkg;

  // Field widths.
  localparam int CFG_W    = 9;
  localparam int IDX_W    = 2;
  localparam int COORD_W  = 10;
  localparam int COLOR_W  = 8;
  localparam int PIX_W    = 3 * COLOR_W;
  localparam int SIZE_W   = 11;

  // Full output size: at most 511 rows times a whole factor of 5.
  localparam int OSZ_W    = 12;
  // Source index quotient is always below the clamped input size.
  localparam int QUO_W    = CFG_W;
  // Coordinate times input size.
  localparam int PROD_W   = COORD_W + CFG_W;
  // Fractional scale: size times percent below 100.
  localparam int PCT_LO_W = 7;
  localparam int LOPROD_W = 16;

  // x / 100 for x below 2^16: floor(x * 655 / 2^16) is low by at most one.
  localparam int RECIP_W  = 10;
  localparam int RECIP_SH = 16;
  localparam logic [RECIP_W-1:0] RECIP_100 = 10'd655;

  localparam logic [CFG_W-1:0] PERCENT = 9'd100;

  // Cycles the read sequence waits for the size pipeline to settle.
  localparam int SIZE_LAT = 4;
  localparam int SCNT_W   = $clog2(SIZE_LAT);

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_IN_ROWS = 2'd0,
    CFG_IN_COLS = 2'd1,
    CFG_SCALE   = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_pix;     // write beat accepted
    logic cap;        // read beat accepted, capture coordinates
    logic div_start;  // launch a division
    logic div_col;    // division operands: column side
    logic sr_cap;     // keep the source row quotient
    logic mem_rd;     // read the frame store
    logic out_load;   // load the result register
    logic out_err;    // result is an out-of-range error
  } nns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_err;
    logic div_done;
    logic out_free;
  } nns_sts_t;

  // Whole part of a percent value below 512.
  function automatic logic [2:0] pct_whole(input logic [CFG_W-1:0] pct);
    logic [2:0] q;
    if (pct >= 9'd500)      q = 3'd5;
    else if (pct >= 9'd400) q = 3'd4;
    else if (pct >= 9'd300) q = 3'd3;
    else if (pct >= 9'd200) q = 3'd2;
    else if (pct >= 9'd100) q = 3'd1;
    else                    q = 3'd0;
    return q;
  endfunction

endpackage

### rtl/nns_ifs.sv
// ----------------------------------------------------------------------------
// Scaler channel interfaces
// Valid/ready channels for pixel requests, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Request channel: pixel writes and scaled pixel reads.
interface nns_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [nns_pkg::COORD_W-1:0]         row;
  logic [nns_pkg::COORD_W-1:0]         col;
  logic [nns_pkg::COLOR_W-1:0]         red_in;
  logic [nns_pkg::COLOR_W-1:0]         green_in;
  logic [nns_pkg::COLOR_W-1:0]         blue_in;

  modport source (output valid, op, row, col, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, op, row, col, red_in, green_in, blue_in, output ready);
endinterface

// Result channel: one beat per read request.
interface nns_out_if;
  logic                                valid;
  logic                                ready;
  logic [nns_pkg::COLOR_W-1:0]         red_out;
  logic [nns_pkg::COLOR_W-1:0]         green_out;
  logic [nns_pkg::COLOR_W-1:0]         blue_out;
  logic [nns_pkg::SIZE_W-1:0]          out_rows;
  logic [nns_pkg::SIZE_W-1:0]          out_cols;
  logic                                status;

  modport source (output valid, red_out, green_out, blue_out, out_rows, out_cols, status,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_rows, out_cols, status,
                  output ready);
endinterface

// Register write channel.
interface nns_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [nns_pkg::IDX_W-1:0]           index;
  logic [nns_pkg::CFG_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/nns_div.sv
// ----------------------------------------------------------------------------
// Scaler divider
// Restoring divider, one quotient bit per cycle, for source index lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nns_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [nns_pkg::PROD_W-1:0]    dividend,
  input  logic [nns_pkg::OSZ_W-1:0]     divisor,
  output logic                          done,
  output logic [nns_pkg::QUO_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(nns_pkg::QUO_W);

  logic                         busy_r;
  logic                         done_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [nns_pkg::OSZ_W-1:0]    rem_r;
  logic [nns_pkg::OSZ_W-1:0]    dsr_r;
  logic [nns_pkg::QUO_W-1:0]    quo_r;
  logic [nns_pkg::OSZ_W:0]      shifted;
  logic [nns_pkg::OSZ_W:0]      diff;
  logic                         take;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem_r, quo_r[nns_pkg::QUO_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign take    = (shifted >= {1'b0, dsr_r});

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(nns_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // The quotient is known to fit QUO_W bits, so the upper dividend bits start
  // as the partial remainder and only the low bits are shifted through.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= nns_pkg::OSZ_W'(dividend[nns_pkg::PROD_W-1:nns_pkg::QUO_W]);
      quo_r <= dividend[nns_pkg::QUO_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[nns_pkg::OSZ_W-1:0] : shifted[nns_pkg::OSZ_W-1:0];
      quo_r <= {quo_r[nns_pkg::QUO_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/nns_ctrl.sv
// ----------------------------------------------------------------------------
// Scaler controller
// Sequences each read through the size check and, when in range, two divisions and the frame read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nns_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  nns_pkg::nns_sts_t  sts,
  output nns_pkg::nns_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_CHECK,
    S_DIV_ROW,
    S_DIV_COL,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [nns_pkg::SCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         err_r, err_nxt;
  logic                         in_ready_r;
  logic                         accept;

  assign accept = in_valid && in_ready_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == nns_pkg::OP_READ) begin
            cmd.cap   = 1'b1;
            cnt_nxt   = nns_pkg::SCNT_W'(nns_pkg::SIZE_LAT - 1);
            state_nxt = S_SIZE;
          end else begin
            cmd.wr_pix = 1'b1;
          end
        end
      end
      S_SIZE: begin
        if (cnt_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.range_err) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          err_nxt       = 1'b0;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (sts.div_done) begin
          cmd.sr_cap    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_col   = 1'b1;
          state_nxt     = S_DIV_COL;
        end
      end
      S_DIV_COL: begin
        if (sts.div_done) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_err = err_r;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      err_r      <= 1'b0;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      err_r      <= err_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

### rtl/nns_dp.sv
// ----------------------------------------------------------------------------
// Scaler datapath
// Registers, output size pipeline, frame store, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nns_dp #(
  parameter int MAX_DIM   = 256,
  parameter int MAX_SCALE = 400
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request payload
  input  logic [nns_pkg::COORD_W-1:0]    in_row,
  input  logic [nns_pkg::COORD_W-1:0]    in_col,
  input  logic [nns_pkg::PIX_W-1:0]      in_pix,
  // register writes
  input  logic                           cfg_valid,
  input  logic [nns_pkg::IDX_W-1:0]      cfg_index,
  input  logic [nns_pkg::CFG_W-1:0]      cfg_data,
  // result
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nns_pkg::PIX_W-1:0]      out_pix,
  output logic [nns_pkg::SIZE_W-1:0]     out_rows,
  output logic [nns_pkg::SIZE_W-1:0]     out_cols,
  output logic                           out_status,
  // control
  input  nns_pkg::nns_cmd_t              cmd,
  output nns_pkg::nns_sts_t              sts
);

  localparam int CFG_MAX = 2 ** nns_pkg::CFG_W - 1;
  localparam logic [nns_pkg::CFG_W-1:0] DIM_CAP =
    nns_pkg::CFG_W'((MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM);
  localparam logic [nns_pkg::CFG_W-1:0] SCALE_CAP =
    nns_pkg::CFG_W'((MAX_SCALE > CFG_MAX) ? CFG_MAX : MAX_SCALE);
  localparam int DIM_AW  = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_AW;
  localparam int DEPTH   = 2 ** ADDR_W;

  // Configuration registers.
  logic [nns_pkg::CFG_W-1:0]     in_rows_r, in_cols_r, scale_r;
  logic [nns_pkg::CFG_W-1:0]     dim_c [2];
  logic [nns_pkg::CFG_W-1:0]     pct_c;
  logic [2:0]                    whole_c;

  // Output size pipeline.
  logic [nns_pkg::LOPROD_W-1:0]  lo_r [2];
  logic [nns_pkg::LOPROD_W-1:0]  lo2_r [2];
  logic [nns_pkg::OSZ_W-1:0]     hi_r [2];
  logic [nns_pkg::OSZ_W-1:0]     hi2_r [2];
  logic [nns_pkg::CFG_W-1:0]     est_r [2];
  logic [nns_pkg::OSZ_W-1:0]     osz_r [2];
  logic                          sel_r, sel2_r;

  // Read sequence.
  logic [nns_pkg::COORD_W-1:0]   row_r, col_r;
  logic [nns_pkg::QUO_W-1:0]     sr_r;
  logic [nns_pkg::COORD_W-1:0]   div_coord;
  logic [nns_pkg::CFG_W-1:0]     div_dim;
  logic [nns_pkg::PROD_W-1:0]    dividend;
  logic [nns_pkg::OSZ_W-1:0]     divisor;
  logic                          div_done;
  logic [nns_pkg::QUO_W-1:0]     quotient;
  logic [nns_pkg::QUO_W-1:0]     sr_fix, sc_fix;

  // Frame store.
  logic [nns_pkg::PIX_W-1:0]     mem [DEPTH];
  logic [ADDR_W-1:0]             wr_addr, rd_addr;
  logic                          wr_in_range;
  logic [nns_pkg::PIX_W-1:0]     rd_pix_r;

  // Result register.
  logic                          out_valid_r;
  logic [nns_pkg::PIX_W-1:0]     out_pix_r;
  logic [nns_pkg::SIZE_W-1:0]    out_rows_r, out_cols_r;
  logic                          out_status_r;

  // floor(x * 655 / 2^16), which is floor(x / 100) or one less.
  function automatic logic [nns_pkg::CFG_W-1:0] est_full(
    input logic [nns_pkg::LOPROD_W-1:0] x
  );
    logic [nns_pkg::LOPROD_W+nns_pkg::RECIP_W-1:0] p;
    p = {{nns_pkg::RECIP_W{1'b0}}, x} *
        {{nns_pkg::LOPROD_W{1'b0}}, nns_pkg::RECIP_100};
    return p[nns_pkg::RECIP_SH +: nns_pkg::CFG_W];
  endfunction

  // Add one where the remainder still reaches 100.
  function automatic logic [nns_pkg::CFG_W-1:0] fix_est(
    input logic [nns_pkg::LOPROD_W-1:0] x,
    input logic [nns_pkg::CFG_W-1:0]    est
  );
    logic [nns_pkg::LOPROD_W-1:0] back;
    logic [nns_pkg::LOPROD_W-1:0] rem;
    back = {{(nns_pkg::LOPROD_W - nns_pkg::CFG_W){1'b0}}, est} *
           nns_pkg::LOPROD_W'(nns_pkg::PERCENT);
    rem  = x - back;
    return (rem >= nns_pkg::LOPROD_W'(nns_pkg::PERCENT)) ? est + 1'b1 : est;
  endfunction

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rows_r <= nns_pkg::CFG_W'(1);
      in_cols_r <= nns_pkg::CFG_W'(1);
      scale_r   <= nns_pkg::PERCENT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nns_pkg::CFG_IN_ROWS: in_rows_r <= cfg_data;
        nns_pkg::CFG_IN_COLS: in_cols_r <= cfg_data;
        nns_pkg::CFG_SCALE:   scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX_DIM and the scale to MAX_SCALE.
  always_comb begin
    dim_c[0] = (in_rows_r == '0) ? nns_pkg::CFG_W'(1) :
               ((in_rows_r > DIM_CAP) ? DIM_CAP : in_rows_r);
    dim_c[1] = (in_cols_r == '0) ? nns_pkg::CFG_W'(1) :
               ((in_cols_r > DIM_CAP) ? DIM_CAP : in_cols_r);
    pct_c    = (scale_r > SCALE_CAP) ? SCALE_CAP : scale_r;
    whole_c  = nns_pkg::pct_whole(pct_c);
  end

  // Output size, three stages: products, reciprocal estimate, correction.
  always_ff @(posedge clk) begin
    sel_r  <= (pct_c >= nns_pkg::PERCENT);
    sel2_r <= sel_r;
    for (int d = 0; d < 2; d++) begin
      lo_r[d]  <= {{(nns_pkg::LOPROD_W - nns_pkg::CFG_W){1'b0}}, dim_c[d]} *
                  {{(nns_pkg::LOPROD_W - nns_pkg::PCT_LO_W){1'b0}},
                   pct_c[nns_pkg::PCT_LO_W-1:0]};
      hi_r[d]  <= {{(nns_pkg::OSZ_W - nns_pkg::CFG_W){1'b0}}, dim_c[d]} *
                  {{(nns_pkg::OSZ_W - 3){1'b0}}, whole_c};
      lo2_r[d] <= lo_r[d];
      hi2_r[d] <= hi_r[d];
      est_r[d] <= est_full(lo_r[d]);
      osz_r[d] <= sel2_r ? hi2_r[d] : nns_pkg::OSZ_W'(fix_est(lo2_r[d], est_r[d]));
    end
  end

  // Read coordinates.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.sr_cap) begin
      sr_r <= quotient;
    end
  end

  // Source index = coordinate * input size / output size.
  assign div_coord = cmd.div_col ? col_r : row_r;
  assign div_dim   = cmd.div_col ? dim_c[1] : dim_c[0];
  assign dividend  = {{nns_pkg::CFG_W{1'b0}}, div_coord} *
                     {{nns_pkg::COORD_W{1'b0}}, div_dim};
  assign divisor   = cmd.div_col ? osz_r[1] : osz_r[0];

  nns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Keep the source index inside the stored image.
  assign sr_fix = (sr_r >= dim_c[0]) ? dim_c[0] - 1'b1 : sr_r;
  assign sc_fix = (quotient >= dim_c[1]) ? dim_c[1] - 1'b1 : quotient;

  // Frame store: write beats inside the image, one registered read port.
  assign wr_in_range = (in_row < nns_pkg::COORD_W'(dim_c[0])) &&
                       (in_col < nns_pkg::COORD_W'(dim_c[1]));
  assign wr_addr     = {DIM_AW'(in_row), DIM_AW'(in_col)};
  assign rd_addr     = {DIM_AW'(sr_fix), DIM_AW'(sc_fix)};

  always_ff @(posedge clk) begin
    if (cmd.wr_pix && wr_in_range) begin
      mem[wr_addr] <= in_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_pix_r <= mem[rd_addr];
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; an error beat carries black.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r    <= cmd.out_err ? '0 : rd_pix_r;
      out_rows_r   <= osz_r[0][nns_pkg::SIZE_W-1:0];
      out_cols_r   <= osz_r[1][nns_pkg::SIZE_W-1:0];
      out_status_r <= cmd.out_err;
    end
  end

  // Status to the controller.
  assign sts.range_err = (nns_pkg::OSZ_W'(row_r) >= osz_r[0]) ||
                         (nns_pkg::OSZ_W'(col_r) >= osz_r[1]);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_pix    = out_pix_r;
  assign out_rows   = out_rows_r;
  assign out_cols   = out_cols_r;
  assign out_status = out_status_r;

endmodule

### rtl/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler
// Frame store with a nearest-neighbor lookup into a scaled output image.
// ----------------------------------------------------------------------------
//   Channel  Dir  Beat contents
//   in_ch    in   op, row, col, red_in, green_in, blue_in
//   out_ch   out  red_out, green_out, blue_out, out_rows, out_cols, status
//   cfg_ch   in   index, data (in_rows, in_cols, scale_percent)
//
// A write beat yields no result, and a new beat can be taken in the cycle after it.
// A read beat holds off new beats while it runs through size settling, a range check,
// a row and a column divider pass, the frame read and a result load that waits while
// the result register is full; an out-of-range read skips the divider passes.
// A finished read waits in the result register while the next beat enters.
// Reset is synchronous; the frame store is not cleared. Register writes are always taken.
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler #(
  parameter int MAX_DIM   = 256,
  parameter int MAX_SCALE = 400
) (
  input  logic           clk,
  input  logic           rst_n,
  nns_in_if.sink         in_ch,
  nns_out_if.source      out_ch,
  nns_cfg_if.sink        cfg_ch
);

  nns_pkg::nns_cmd_t               cmd;
  nns_pkg::nns_sts_t               sts;
  logic [nns_pkg::PIX_W-1:0]       in_pix;
  logic [nns_pkg::PIX_W-1:0]       out_pix;

  assign in_pix       = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
  assign cfg_ch.ready = 1'b1;

  nns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nns_dp #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_row     (in_ch.row),
    .in_col     (in_ch.col),
    .in_pix     (in_pix),
    .cfg_valid  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pix    (out_pix),
    .out_rows   (out_ch.out_rows),
    .out_cols   (out_ch.out_cols),
    .out_status (out_ch.status),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Split the stored pixel back into its channels.
  assign out_ch.red_out   = out_pix[2*nns_pkg::COLOR_W +: nns_pkg::COLOR_W];
  assign out_ch.green_out = out_pix[nns_pkg::COLOR_W +: nns_pkg::COLOR_W];
  assign out_ch.blue_out  = out_pix[0 +: nns_pkg::COLOR_W];

endmodule

### rtl/nns_chk.sv
// ----------------------------------------------------------------------------
// Scaler port checker
// Temporal checks on the scaler ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_neighbor_image_scaler_macros.svh"

module nns_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_op,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [nns_pkg::COLOR_W-1:0]    red_out,
  input logic [nns_pkg::COLOR_W-1:0]    green_out,
  input logic [nns_pkg::COLOR_W-1:0]    blue_out,
  input logic [nns_pkg::SIZE_W-1:0]     out_rows,
  input logic [nns_pkg::SIZE_W-1:0]     out_cols,
  input logic                           status
);

  localparam int RES_W = nns_pkg::PIX_W + 2 * nns_pkg::SIZE_W + 1;

  logic [nns_pkg::PIX_W-1:0]  res_pix;
  logic [RES_W-1:0]           res_bus;
  logic                       res_stall;
  logic                       err_beat;
  logic                       wr_quiet;

  assign res_pix   = {red_out, green_out, blue_out};
  assign res_bus   = {res_pix, out_rows, out_cols, status};
  assign res_stall = out_valid && !out_ready;
  assign err_beat  = out_valid && status;
  assign wr_quiet  = in_valid && in_ready && (in_op == nns_pkg::OP_WRITE) && !out_valid;

  // A stalled result beat stays and keeps its contents.
  `NNS_ASSERT_NEXT(a_out_hold, clk, rst_n, res_stall, out_valid, "result beat dropped")
  `NNS_ASSERT_NEXT(a_out_stable, clk, rst_n, res_stall, $stable(res_bus), "stalled result changed")

  // An out-of-range read returns black.
  `NNS_ASSERT_SAME(a_err_black, clk, rst_n, err_beat, res_pix == '0, "error beat carries color")

  // A pixel write never raises a result.
  `NNS_ASSERT_NEXT(a_write_silent, clk, rst_n, wr_quiet, !out_valid, "write produced a result")

endmodule

bind nearest_neighbor_image_scaler nns_chk u_nns_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red_out   (out_ch.red_out),
  .green_out (out_ch.green_out),
  .blue_out  (out_ch.blue_out),
  .out_rows  (out_ch.out_rows),
  .out_cols  (out_ch.out_cols),
  .status    (out_ch.status)
);

### test/nearest_neighbor_image_scaler_tb.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler testbench
// Writes pixels into the frame store and reads scaled pixels back. Every read
// result is checked field by field against a local model of the scaler, over
// several image sizes and scale settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_tb;

  localparam int MAX_DIM      = 256;
  localparam int MAX_SCALE    = 400;
  localparam int ITEM_GOAL    = 600;
  localparam int QUIET_AT     = 520;
  localparam int SETTLE_CYC   = 32;
  localparam int LIMIT_CYC    = 400000;

  // Register index that maps to no register.
  localparam logic [nns_pkg::IDX_W-1:0] CFG_NO_REG = 2'd3;

  // Result status codes.
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    logic                        op;
    logic [nns_pkg::COORD_W-1:0] row;
    logic [nns_pkg::COORD_W-1:0] col;
    logic [nns_pkg::COLOR_W-1:0] red;
    logic [nns_pkg::COLOR_W-1:0] green;
    logic [nns_pkg::COLOR_W-1:0] blue;
  } pix_req_t;

  typedef struct packed {
    logic [nns_pkg::COLOR_W-1:0] red;
    logic [nns_pkg::COLOR_W-1:0] green;
    logic [nns_pkg::COLOR_W-1:0] blue;
    logic [nns_pkg::SIZE_W-1:0]  rows;
    logic [nns_pkg::SIZE_W-1:0]  cols;
    logic                        status;
  } pix_res_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  // One line of the directed table: a register write or a request beat.
  typedef struct packed {
    row_kind_t                 kind;
    logic [nns_pkg::IDX_W-1:0] idx;
    logic [nns_pkg::CFG_W-1:0] data;
    pix_req_t                  req;
    logic                      typed;
    pix_res_t                  res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  nns_in_if  in_ch ();
  nns_out_if out_ch ();
  nns_cfg_if cfg_ch ();

  nearest_neighbor_image_scaler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow registers and frame contents as the scaler should hold them.
  logic [nns_pkg::CFG_W-1:0] rows_cfg;
  logic [nns_pkg::CFG_W-1:0] cols_cfg;
  logic [nns_pkg::CFG_W-1:0] pct_cfg;
  logic [nns_pkg::PIX_W-1:0] frame_mdl [MAX_DIM*MAX_DIM];
  bit                        written_map [MAX_DIM*MAX_DIM];

  pix_res_t    pending_pix_q [$];
  dir_row_t    dir_tab [$];
  int          errors = 0;
  int          items_done;
  int unsigned cycle_cnt = 0;
  logic        calm;
  logic        idle_off;

  assign idle_off = calm || (items_done >= QUIET_AT);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYC) begin
      $display("%0t: run limit reached", $time);
      $display("simulation failed");
      $finish;
    end
  end

  // Effective image dimension after clamping the register value.
  function automatic int eff_dim(logic [nns_pkg::CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  // Scaled size of one dimension under the current scale setting.
  function automatic int out_dim(int d);
    int p;
    p = (pct_cfg > MAX_SCALE) ? MAX_SCALE : int'(pct_cfg);
    if (p >= int'(nns_pkg::PERCENT)) return d * (p / int'(nns_pkg::PERCENT));
    return (d * p) / int'(nns_pkg::PERCENT);
  endfunction

  // Frame address of the source pixel of an output pixel, or -1 off the image.
  function automatic int src_index(logic [nns_pkg::COORD_W-1:0] row,
                                   logic [nns_pkg::COORD_W-1:0] col);
    int rows, cols, orows, ocols, sr, sc;
    rows  = eff_dim(rows_cfg);
    cols  = eff_dim(cols_cfg);
    orows = out_dim(rows);
    ocols = out_dim(cols);
    if (int'(row) >= orows || int'(col) >= ocols) return -1;
    sr = (int'(row) * rows) / orows;
    sc = (int'(col) * cols) / ocols;
    if (sr >= rows) sr = rows - 1;
    if (sc >= cols) sc = cols - 1;
    return sr * MAX_DIM + sc;
  endfunction

  // Result of a read of output pixel (row, col).
  function automatic pix_res_t lookup_pixel(logic [nns_pkg::COORD_W-1:0] row,
                                            logic [nns_pkg::COORD_W-1:0] col);
    pix_res_t r;
    int       idx;
    r      = '0;
    r.rows = nns_pkg::SIZE_W'(out_dim(eff_dim(rows_cfg)));
    r.cols = nns_pkg::SIZE_W'(out_dim(eff_dim(cols_cfg)));
    idx    = src_index(row, col);
    if (idx < 0) r.status = ST_RANGE;
    else {r.red, r.green, r.blue} = frame_mdl[idx];
    return r;
  endfunction

  function automatic pix_req_t rand_req(logic op, int row, int col);
    pix_req_t q;
    q.op    = op;
    q.row   = nns_pkg::COORD_W'(row);
    q.col   = nns_pkg::COORD_W'(col);
    q.red   = nns_pkg::COLOR_W'($urandom_range(0, 255));
    q.green = nns_pkg::COLOR_W'($urandom_range(0, 255));
    q.blue  = nns_pkg::COLOR_W'($urandom_range(0, 255));
    return q;
  endfunction

  // Builders for the directed table.
  function automatic dir_row_t wr_px(int row, int col, logic [nns_pkg::PIX_W-1:0] rgb);
    dir_row_t d;
    d         = '0;
    d.kind    = ROW_BEAT;
    d.req.op  = nns_pkg::OP_WRITE;
    d.req.row = nns_pkg::COORD_W'(row);
    d.req.col = nns_pkg::COORD_W'(col);
    {d.req.red, d.req.green, d.req.blue} = rgb;
    return d;
  endfunction

  function automatic dir_row_t rd_px(int row, int col);
    dir_row_t d;
    d         = '0;
    d.kind    = ROW_BEAT;
    d.req.op  = nns_pkg::OP_READ;
    d.req.row = nns_pkg::COORD_W'(row);
    d.req.col = nns_pkg::COORD_W'(col);
    return d;
  endfunction

  function automatic dir_row_t rd_px_is(int row, int col, logic [nns_pkg::PIX_W-1:0] rgb,
                                        int orows, int ocols, logic st);
    dir_row_t d;
    d            = rd_px(row, col);
    d.typed      = 1'b1;
    {d.res.red, d.res.green, d.res.blue} = rgb;
    d.res.rows   = nns_pkg::SIZE_W'(orows);
    d.res.cols   = nns_pkg::SIZE_W'(ocols);
    d.res.status = st;
    return d;
  endfunction

  function automatic dir_row_t reg_wr(logic [nns_pkg::IDX_W-1:0] idx, int data);
    dir_row_t d;
    d      = '0;
    d.kind = ROW_REG;
    d.idx  = idx;
    d.data = nns_pkg::CFG_W'(data);
    return d;
  endfunction

  // Wait until every read has answered and the last write has landed.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_pix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register write; the first of a group waits for the block to go idle.
  task automatic write_reg(input logic [nns_pkg::IDX_W-1:0] idx, input int data);
    if (!cfg_ch.valid) drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= nns_pkg::CFG_W'(data);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      nns_pkg::CFG_IN_ROWS: rows_cfg = nns_pkg::CFG_W'(data);
      nns_pkg::CFG_IN_COLS: cols_cfg = nns_pkg::CFG_W'(data);
      nns_pkg::CFG_SCALE:   pct_cfg  = nns_pkg::CFG_W'(data);
      default: ;
    endcase
  endtask

  // One request beat, with an optional gap in front of it.
  task automatic send_beat(input pix_req_t req, input bit typed, input pix_res_t res);
    int gap;
    if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= req.op;
    in_ch.row      <= req.row;
    in_ch.col      <= req.col;
    in_ch.red_in   <= req.red;
    in_ch.green_in <= req.green;
    in_ch.blue_in  <= req.blue;
    do @(posedge clk); while (!in_ch.ready);
    // Beat taken: update the model or queue the expected result.
    if (req.op == nns_pkg::OP_READ) begin
      pending_pix_q.push_back(typed ? res : lookup_pixel(req.row, req.col));
      items_done++;
    end else if (int'(req.row) < eff_dim(rows_cfg) &&
                 int'(req.col) < eff_dim(cols_cfg)) begin
      frame_mdl[int'(req.row) * MAX_DIM + int'(req.col)] = {req.red, req.green, req.blue};
      written_map[int'(req.row) * MAX_DIM + int'(req.col)] = 1'b1;
      items_done++;
    end
  endtask

  // Make sure the pixel a read will copy has been written.
  task automatic ensure_source(input logic [nns_pkg::COORD_W-1:0] row,
                               input logic [nns_pkg::COORD_W-1:0] col);
    int idx;
    idx = src_index(row, col);
    if (idx >= 0 && !written_map[idx])
      send_beat(rand_req(nns_pkg::OP_WRITE, idx / MAX_DIM, idx % MAX_DIM), 1'b0, '0);
  endtask

  // One setting of the registers followed by a burst of traffic.
  task automatic run_phase(input int rows_w, input int cols_w, input int pct_w,
                           input bit calm_phase);
    int rows, cols, orows, ocols, n_ops, r, c;
    pix_req_t q;
    write_reg(nns_pkg::CFG_IN_ROWS, rows_w);
    write_reg(nns_pkg::CFG_IN_COLS, cols_w);
    write_reg(nns_pkg::CFG_SCALE, pct_w);
    if ($urandom_range(0, 5) == 0) write_reg(CFG_NO_REG, $urandom_range(0, 511));
    calm  = calm_phase;
    rows  = eff_dim(rows_cfg);
    cols  = eff_dim(cols_cfg);
    orows = out_dim(rows);
    ocols = out_dim(cols);
    // Small images are filled in raster order first.
    if (rows * cols <= 64) begin
      for (r = 0; r < rows; r++)
        for (c = 0; c < cols; c++)
          send_beat(rand_req(nns_pkg::OP_WRITE, r, c), 1'b0, '0);
    end
    n_ops = $urandom_range(15, 40);
    repeat (n_ops) begin
      case ($urandom_range(0, 9))
        0: q = rand_req(nns_pkg::OP_WRITE, $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
        1, 2: q = rand_req(nns_pkg::OP_WRITE, $urandom_range(0, rows - 1),
                           $urandom_range(0, cols - 1));
        3: q = rand_req(nns_pkg::OP_READ, $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
        default: begin
          if (orows > 0 && ocols > 0)
            q = rand_req(nns_pkg::OP_READ, $urandom_range(0, orows - 1),
                         $urandom_range(0, ocols - 1));
          else
            q = rand_req(nns_pkg::OP_READ, $urandom_range(0, 1023),
                         $urandom_range(0, 1023));
        end
      endcase
      if (q.op == nns_pkg::OP_READ) ensure_source(q.row, q.col);
      send_beat(q, 1'b0, '0);
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 0 : 511;
      1: return $urandom_range(9, 511);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 99);
      1: return $urandom_range(0, 1);
      2: return $urandom_range(401, 511);
      default: return $urandom_range(100, 400);
    endcase
  endfunction

  // Field compare for one result beat.
  task automatic cmp_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    pix_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pix_q.size() == 0) begin
        $display("%0t: result beat with no read pending, expected none, actual %h",
                 $time, {out_ch.red_out, out_ch.green_out, out_ch.blue_out});
        errors++;
      end else begin
        e = pending_pix_q.pop_front();
        cmp_field("red_out", e.red, out_ch.red_out);
        cmp_field("green_out", e.green, out_ch.green_out);
        cmp_field("blue_out", e.blue, out_ch.blue_out);
        cmp_field("out_rows", e.rows, out_ch.out_rows);
        cmp_field("out_cols", e.cols, out_ch.out_cols);
        cmp_field("status", e.status, out_ch.status);
      end
    end
  end

  // Result ready with random stall bursts.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence.
  initial begin
    items_done = 0;
    calm       = 1'b0;
    rows_cfg   = 9'd1;
    cols_cfg   = 9'd1;
    pct_cfg    = nns_pkg::PERCENT;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= nns_pkg::OP_WRITE;
    in_ch.row      <= '0;
    in_ch.col      <= '0;
    in_ch.red_in   <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= nns_pkg::CFG_IN_ROWS;
    cfg_ch.data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset size, dropped writes, range errors, clamped and
    // empty sizes, an unused register index and the largest output image.
    dir_tab = '{
      wr_px(0, 0, 24'hFF00AA),
      rd_px_is(0, 0, 24'hFF00AA, 1, 1, ST_OK),
      rd_px_is(0, 1, 24'h0, 1, 1, ST_RANGE),
      rd_px_is(1023, 1023, 24'h0, 1, 1, ST_RANGE),
      wr_px(0, 1, 24'h112233),
      rd_px_is(0, 0, 24'hFF00AA, 1, 1, ST_OK),
      reg_wr(nns_pkg::CFG_IN_ROWS, 2), reg_wr(nns_pkg::CFG_IN_COLS, 2),
      reg_wr(nns_pkg::CFG_SCALE, 250),
      wr_px(0, 1, 24'h00FF00), wr_px(1, 0, 24'h0000FF), wr_px(1, 1, 24'hFFFFFF),
      rd_px(3, 3), rd_px(2, 1),
      rd_px_is(4, 0, 24'h0, 4, 4, ST_RANGE),
      reg_wr(nns_pkg::CFG_SCALE, 50), rd_px(0, 0),
      reg_wr(nns_pkg::CFG_SCALE, 0), rd_px_is(0, 0, 24'h0, 0, 0, ST_RANGE),
      reg_wr(nns_pkg::CFG_IN_ROWS, 0), reg_wr(nns_pkg::CFG_IN_COLS, 511),
      reg_wr(nns_pkg::CFG_SCALE, 511),
      rd_px(3, 1023), wr_px(0, 1023, 24'h123456), wr_px(1, 0, 24'hABCDEF),
      rd_px_is(4, 0, 24'h0, 4, 1024, ST_RANGE),
      reg_wr(CFG_NO_REG, 0), rd_px(0, 0),
      reg_wr(nns_pkg::CFG_IN_ROWS, 256), reg_wr(nns_pkg::CFG_IN_COLS, 256),
      reg_wr(nns_pkg::CFG_SCALE, 400),
      rd_px(1023, 1023), rd_px(0, 0),
      reg_wr(nns_pkg::CFG_SCALE, 1), rd_px(1, 1), rd_px_is(2, 0, 24'h0, 2, 2, ST_RANGE)
    };
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_REG) begin
        write_reg(dir_tab[k].idx, int'(dir_tab[k].data));
      end else begin
        if (dir_tab[k].req.op == nns_pkg::OP_READ)
          ensure_source(dir_tab[k].req.row, dir_tab[k].req.col);
        send_beat(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].res);
      end
    end

    // Random part: corner settings first, then mostly small random images.
    run_phase(256, 256, 400, 1'b0);
    run_phase(1, 1, 1, 1'b0);
    run_phase(511, 0, 99, 1'b1);
    run_phase(3, 5, 300, 1'b0);
    while (items_done < ITEM_GOAL)
      run_phase(pick_dim(), pick_dim(), pick_pct(), $urandom_range(0, 3) == 0);

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/nns_pkg.sv
rtl/nns_ifs.sv
rtl/nns_div.sv
rtl/nns_ctrl.sv
rtl/nns_dp.sv
rtl/nearest_neighbor_image_scaler.sv
rtl/nns_chk.sv
test/nearest_neighbor_image_scaler_tb.sv
